/* hw/rtl/ppc_pkg.sv */
// ppc_pkg: shared types and fixed field widths for the perceptron classify/train unit
// no dependencies; imported by ppc_lane, ppc_merge, perceptron_classify_train_unit and the testbench
package ppc_pkg;

   // fixed transaction field widths
   localparam int THRESH_W  = 21;
   localparam int SUM_OUT_W = 21;
   localparam int PATTERN_W = 25;
   localparam int INDEX_W   = 5;
   localparam int VALUE_W   = 16;

   // operation codes carried on the request channel
   typedef enum logic [1:0] {
      OP_CLASSIFY = 2'd0,
      OP_TRAIN    = 2'd1,
      OP_WRITE    = 2'd2,
      OP_CLEAR    = 2'd3
   } opcode_type;

   // per-lane weight update command, issued when a transaction completes
   typedef struct packed {
      logic commit;
      logic clear;
      logic write;
      logic adjust;
      logic up;
   } lane_cmd_type;

endpackage

/* hw/rtl/ppc_lane.sv */
// ppc_lane: one grid row of weights with its partial sum and update logic
// depends on ppc_pkg (lane_cmd_type, INDEX_W)
module ppc_lane import ppc_pkg::*; #(
   parameter int GRID_SIDE   = 5,
   parameter int WEIGHT_BITS = 16,
   parameter int LANE_ID     = 0,
   localparam int ROW_W      = WEIGHT_BITS + $clog2(GRID_SIDE)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          capture,
   input  logic [GRID_SIDE-1:0]          row_bits,
   input  lane_cmd_type                  cmd,
   input  logic [INDEX_W-1:0]            wr_index,
   input  logic signed [WEIGHT_BITS-1:0] wr_weight,
   output logic signed [ROW_W-1:0]       row_sum
);

   localparam int COL_W = $clog2(GRID_SIDE);
   localparam int BASE  = LANE_ID * GRID_SIDE;
   localparam logic signed [WEIGHT_BITS-1:0] WMAX = {1'b0, {(WEIGHT_BITS-1){1'b1}}};
   localparam logic signed [WEIGHT_BITS-1:0] WMIN = {1'b1, {(WEIGHT_BITS-1){1'b0}}};
   localparam logic signed [WEIGHT_BITS-1:0] W_ONE = WEIGHT_BITS'(1);

   logic signed [WEIGHT_BITS-1:0] weights_ff [GRID_SIDE];
   logic signed [WEIGHT_BITS-1:0] weights_in [GRID_SIDE];
   logic [GRID_SIDE-1:0]          row_bits_ff;
   logic [GRID_SIDE-1:0]          row_bits_in;
   logic signed [ROW_W-1:0]       row_sum_ff;
   logic signed [ROW_W-1:0]       row_sum_in;
   logic signed [ROW_W-1:0]       sum_now;
   logic                          wr_hit;
   logic [COL_W-1:0]              wr_col;

   // partial sum of this row's weights at the set pixels
   always_comb begin
      sum_now = '0;
      for (int c = 0; c < GRID_SIDE; c++) begin
         if (row_bits[c]) begin
            sum_now = sum_now + ROW_W'(weights_ff[c]);
         end
      end
   end

   // hold the partial sum and pixels for the transaction in flight
   assign row_sum_in  = capture ? sum_now : row_sum_ff;
   assign row_bits_in = capture ? row_bits : row_bits_ff;

   // does a weight write land in this row
   assign wr_hit = (int'(wr_index) >= BASE) && (int'(wr_index) < BASE + GRID_SIDE);
   assign wr_col = COL_W'(int'(wr_index) - BASE);

   // weight update: clear, single write, or saturating +/-1 on set pixels
   always_comb begin
      for (int c = 0; c < GRID_SIDE; c++) begin
         weights_in[c] = weights_ff[c];
         if (cmd.commit) begin
            if (cmd.clear) begin
               weights_in[c] = '0;
            end else if (cmd.write && wr_hit && (wr_col == COL_W'(c))) begin
               weights_in[c] = wr_weight;
            end else if (cmd.adjust && row_bits_ff[c]) begin
               if (cmd.up) begin
                  if (weights_ff[c] != WMAX) begin
                     weights_in[c] = weights_ff[c] + W_ONE;
                  end
               end else begin
                  if (weights_ff[c] != WMIN) begin
                     weights_in[c] = weights_ff[c] - W_ONE;
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < GRID_SIDE; c++) begin
            weights_ff[c] <= '0;
         end
      end else begin
         for (int c = 0; c < GRID_SIDE; c++) begin
            weights_ff[c] <= weights_in[c];
         end
      end
   end

   // per-transaction payload, no reset needed
   always_ff @(posedge clock) begin
      row_sum_ff  <= row_sum_in;
      row_bits_ff <= row_bits_in;
   end

   assign row_sum = row_sum_ff;

endmodule

/* hw/rtl/ppc_merge.sv */
// ppc_merge: adds the lane partial sums, compares with the threshold, saturates the sum
// depends on ppc_pkg (THRESH_W, SUM_OUT_W)
module ppc_merge import ppc_pkg::*; #(
   parameter int GRID_SIDE   = 5,
   parameter int WEIGHT_BITS = 16,
   localparam int ROW_W      = WEIGHT_BITS + $clog2(GRID_SIDE)
) (
   input  logic signed [ROW_W-1:0]     row_sum [GRID_SIDE],
   input  logic signed [THRESH_W-1:0]  threshold,
   output logic                        decision,
   output logic signed [SUM_OUT_W-1:0] sat_sum
);

   localparam int SUM_W = ROW_W + $clog2(GRID_SIDE);
   localparam int CMP_W = (SUM_W > THRESH_W) ? SUM_W : THRESH_W;
   localparam logic signed [SUM_OUT_W-1:0] SAT_MAX = {1'b0, {(SUM_OUT_W-1){1'b1}}};
   localparam logic signed [SUM_OUT_W-1:0] SAT_MIN = {1'b1, {(SUM_OUT_W-1){1'b0}}};

   logic signed [SUM_W-1:0] total;
   logic signed [CMP_W-1:0] total_wide;
   logic signed [CMP_W-1:0] thresh_wide;

   // sum of the lane results
   always_comb begin
      total = '0;
      for (int r = 0; r < GRID_SIDE; r++) begin
         total = total + SUM_W'(row_sum[r]);
      end
   end

   assign total_wide  = CMP_W'(total);
   assign thresh_wide = CMP_W'(threshold);

   // class decision uses the exact sum
   assign decision = (total_wide >= thresh_wide);

   // reported sum clamps to the output field range
   always_comb begin
      if (total_wide > CMP_W'(SAT_MAX)) begin
         sat_sum = SAT_MAX;
      end else if (total_wide < CMP_W'(SAT_MIN)) begin
         sat_sum = SAT_MIN;
      end else begin
         sat_sum = total_wide[SUM_OUT_W-1:0];
      end
   end

endmodule

/* hw/rtl/perceptron_classify_train_unit.sv */
// perceptron_classify_train_unit: top level of the binary perceptron classify/train unit
// depends on ppc_pkg, ppc_lane (one per grid row) and ppc_merge
//
// Usage:
//  - request channel (req_*): opcode, pattern, target, weight_index, weight_value;
//    a transaction is taken when req_valid is high and req_stall is low
//  - response channel (rsp_*): decision, weighted_sum, mistake; one response per
//    request, taken when rsp_valid is high and rsp_stall is low
//  - csr_write_enable/csr_write_data write the signed threshold; write it only
//    while no request is outstanding
//  - a request is not taken until the previous one has been merged: each row lane
//    registers its partial sum when the request is taken, and the merge, compare
//    and weight write-back happen in the busy state that follows, which the next
//    request's sum must see
//  - req_stall is high while a request is being merged; a response waiting on
//    rsp_stall does not block the next request, but that request is held in the
//    merge state until the output register frees up
//  - reset (synchronous, active high) clears all weights, the threshold and
//    any transaction in flight
module perceptron_classify_train_unit import ppc_pkg::*; #(
   parameter int GRID_SIDE   = 5,
   parameter int WEIGHT_BITS = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [1:0]                  req_opcode,
   input  logic [PATTERN_W-1:0]        req_pattern,
   input  logic                        req_target,
   input  logic [INDEX_W-1:0]          req_weight_index,
   input  logic signed [VALUE_W-1:0]   req_weight_value,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic                        rsp_decision,
   output logic signed [SUM_OUT_W-1:0] rsp_weighted_sum,
   output logic                        rsp_mistake,
   input  logic                        csr_write_enable,
   input  logic signed [THRESH_W-1:0]  csr_write_data
);

   localparam int PIXELS  = GRID_SIDE * GRID_SIDE;
   localparam int ROW_W   = WEIGHT_BITS + $clog2(GRID_SIDE);
   localparam int CLAMP_W = ((WEIGHT_BITS > VALUE_W) ? WEIGHT_BITS : VALUE_W) + 1;
   localparam logic signed [WEIGHT_BITS-1:0] WMAX = {1'b0, {(WEIGHT_BITS-1){1'b1}}};
   localparam logic signed [WEIGHT_BITS-1:0] WMIN = {1'b1, {(WEIGHT_BITS-1){1'b0}}};

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_BUSY = 2'b10
   } state_type;

   state_type                     state_ff, state_in;
   logic signed [THRESH_W-1:0]    threshold_ff, threshold_in;
   opcode_type                    op_ff, op_in;
   logic                          target_ff, target_in;
   logic [INDEX_W-1:0]            index_ff, index_in;
   logic signed [VALUE_W-1:0]     value_ff, value_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          rsp_decision_ff, rsp_decision_in;
   logic signed [SUM_OUT_W-1:0]   rsp_sum_ff, rsp_sum_in;
   logic                          rsp_mistake_ff, rsp_mistake_in;

   logic                          req_take;
   logic                          out_free;
   logic                          finish;
   logic [PIXELS-1:0]             pix;
   logic signed [ROW_W-1:0]       row_sum [GRID_SIDE];
   logic                          decision;
   logic signed [SUM_OUT_W-1:0]   sat_sum;
   logic                          mistake;
   logic signed [CLAMP_W-1:0]     value_wide;
   logic signed [WEIGHT_BITS-1:0] wr_weight;
   lane_cmd_type                  cmd;

   // handshake and sequencing
   assign req_stall = (state_ff == ST_BUSY);
   assign req_take  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign finish    = (state_ff == ST_BUSY) && out_free;

   always_comb begin
      case (state_ff)
         ST_IDLE: state_in = req_take ? ST_BUSY : ST_IDLE;
         ST_BUSY: state_in = finish ? ST_IDLE : ST_BUSY;
         default: state_in = ST_IDLE;
      endcase
   end

   // threshold register
   assign threshold_in = csr_write_enable ? csr_write_data : threshold_ff;

   // request payload held until the merge completes
   assign op_in     = req_take ? opcode_type'(req_opcode) : op_ff;
   assign target_in = req_take ? req_target : target_ff;
   assign index_in  = req_take ? req_weight_index : index_ff;
   assign value_in  = req_take ? req_weight_value : value_ff;

   // pixel map: pattern bits past the port width read as clear
   for (genvar i = 0; i < PIXELS; i++) begin : g_pix
      if (i < PATTERN_W) begin : g_in
         assign pix[i] = req_pattern[i];
      end else begin : g_off
         assign pix[i] = 1'b0;
      end
   end

   // write value clamped to the weight range
   assign value_wide = CLAMP_W'(value_ff);
   always_comb begin
      if (value_wide > CLAMP_W'(WMAX)) begin
         wr_weight = WMAX;
      end else if (value_wide < CLAMP_W'(WMIN)) begin
         wr_weight = WMIN;
      end else begin
         wr_weight = value_wide[WEIGHT_BITS-1:0];
      end
   end

   // training mistake and lane update command
   assign mistake    = (op_ff == OP_TRAIN) && (target_ff != decision);
   assign cmd.commit = finish;
   assign cmd.clear  = (op_ff == OP_CLEAR);
   assign cmd.write  = (op_ff == OP_WRITE);
   assign cmd.adjust = mistake;
   assign cmd.up     = target_ff;

   // one lane per grid row
   for (genvar r = 0; r < GRID_SIDE; r++) begin : g_lane
      ppc_lane #(
         .GRID_SIDE   (GRID_SIDE),
         .WEIGHT_BITS (WEIGHT_BITS),
         .LANE_ID     (r)
      ) u_lane (
         .clock     (clock),
         .reset     (reset),
         .capture   (req_take),
         .row_bits  (pix[r*GRID_SIDE +: GRID_SIDE]),
         .cmd       (cmd),
         .wr_index  (index_ff),
         .wr_weight (wr_weight),
         .row_sum   (row_sum[r])
      );
   end

   // merge lane sums into the decision
   ppc_merge #(
      .GRID_SIDE   (GRID_SIDE),
      .WEIGHT_BITS (WEIGHT_BITS)
   ) u_merge (
      .row_sum   (row_sum),
      .threshold (threshold_ff),
      .decision  (decision),
      .sat_sum   (sat_sum)
   );

   // response register
   always_comb begin
      if (finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end
   assign rsp_decision_in = finish ? decision : rsp_decision_ff;
   assign rsp_sum_in      = finish ? sat_sum : rsp_sum_ff;
   assign rsp_mistake_in  = finish ? mistake : rsp_mistake_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         threshold_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         threshold_ff <= threshold_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff           <= op_in;
      target_ff       <= target_in;
      index_ff        <= index_in;
      value_ff        <= value_in;
      rsp_decision_ff <= rsp_decision_in;
      rsp_sum_ff      <= rsp_sum_in;
      rsp_mistake_ff  <= rsp_mistake_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_decision     = rsp_decision_ff;
   assign rsp_weighted_sum = rsp_sum_ff;
   assign rsp_mistake      = rsp_mistake_ff;

   // a taken request always puts the unit into the busy merge state
   a_take_busy: assert property (@(posedge clock) disable iff (reset)
      req_take |=> req_stall)
      else $error("request taken but unit not busy");

   // completing a transaction always produces a response and frees the input
   a_finish_rsp: assert property (@(posedge clock) disable iff (reset)
      finish |=> (rsp_valid && !req_stall))
      else $error("completion did not present a response");

   // only training can flag a mistake
   a_mistake_train: assert property (@(posedge clock) disable iff (reset)
      (finish && (op_ff != OP_TRAIN)) |=> !rsp_mistake)
      else $error("mistake flagged on a non-training transaction");

   // no response appears without a completing transaction
   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid && !finish) |=> !rsp_valid)
      else $error("response appeared with nothing in flight");

endmodule

/* sim/perceptron_classify_train_unit_test.sv */
`timescale 1ns / 100ps
// perceptron_classify_train_unit_test: self-checking testbench for the binary perceptron unit
// depends on ppc_pkg and perceptron_classify_train_unit; a scoreboard class predicts each response
module perceptron_classify_train_unit_test;
   import ppc_pkg::*;

   localparam int PIXELS      = 25;
   localparam int W_MAX       = 32767;
   localparam int W_MIN       = -32768;
   localparam int T_MAX       = 819175;
   localparam int T_MIN       = -819200;
   localparam int S_MAX       = (1 << (SUM_OUT_W - 1)) - 1;
   localparam int S_MIN       = -(1 << (SUM_OUT_W - 1));
   localparam int N_RANDOM    = 1440;
   localparam int N_PHASES    = 8;
   localparam int MAX_REPORTS = 40;
   localparam logic [PATTERN_W-1:0] ALL_PIXELS = '1;

   // one predicted response
   typedef struct {
      logic decision;
      int   weighted_sum;
      logic mistake;
   } outcome_type;

   // weight and threshold mirror plus the queue of predicted responses
   class perceptron_scoreboard;
      int weights[PIXELS];
      int threshold;
      outcome_type outcome_q[$];
      int errors;
      int checked;
      int corrections;
      int sum_lo;
      int sum_hi;

      function new();
         foreach (weights[i]) weights[i] = 0;
         threshold   = 0;
         errors      = 0;
         checked     = 0;
         corrections = 0;
         sum_lo      = 0;
         sum_hi      = 0;
      endfunction

      static function int clamp(int v, int lo, int hi);
         if (v > hi) return hi;
         if (v < lo) return lo;
         return v;
      endfunction

      function int pending();
         return outcome_q.size();
      endfunction

      // classify with the current weights, then apply the update of the opcode
      function void note_request(opcode_type op, logic [PATTERN_W-1:0] pattern,
                                 logic target, logic [INDEX_W-1:0] index,
                                 logic signed [VALUE_W-1:0] value);
         int sum;
         int delta;
         outcome_type o;
         sum = 0;
         foreach (weights[i]) if (pattern[i]) sum += weights[i];
         o.decision     = (sum >= threshold);
         o.mistake      = 1'b0;
         o.weighted_sum = clamp(sum, S_MIN, S_MAX);
         if (sum < sum_lo) sum_lo = sum;
         if (sum > sum_hi) sum_hi = sum;
         case (op)
            OP_TRAIN: begin
               if (target != o.decision) begin
                  o.mistake = 1'b1;
                  corrections++;
                  delta = target ? 1 : -1;
                  foreach (weights[i])
                     if (pattern[i]) weights[i] = clamp(weights[i] + delta, W_MIN, W_MAX);
               end
            end
            OP_WRITE: begin
               if (index < PIXELS) weights[index] = value;
            end
            OP_CLEAR: begin
               foreach (weights[i]) weights[i] = 0;
            end
            default: ;
         endcase
         outcome_q.insert(outcome_q.size(), o);
      endfunction

      task report(string what);
         errors++;
         if (errors <= MAX_REPORTS) $display("[%0t] mismatch: %s", $time, what);
      endtask

      // compare one accepted response against the oldest prediction
      task check_response(logic decision, logic signed [SUM_OUT_W-1:0] weighted_sum,
                          logic mistake);
         outcome_type o;
         if (outcome_q.size() == 0) begin
            report("response with no request outstanding");
            return;
         end
         o = outcome_q.pop_front();
         checked++;
         if (decision !== o.decision)
            report($sformatf("response %0d decision %b, expected %b",
                             checked, decision, o.decision));
         if (weighted_sum !== SUM_OUT_W'(o.weighted_sum))
            report($sformatf("response %0d weighted_sum %0d, expected %0d",
                             checked, weighted_sum, o.weighted_sum));
         if (mistake !== o.mistake)
            report($sformatf("response %0d mistake %b, expected %b",
                             checked, mistake, o.mistake));
      endtask
   endclass

   logic                        clock = 1'b0;
   logic                        reset;
   logic                        req_valid;
   logic                        req_stall;
   logic [1:0]                  req_opcode;
   logic [PATTERN_W-1:0]        req_pattern;
   logic                        req_target;
   logic [INDEX_W-1:0]          req_weight_index;
   logic signed [VALUE_W-1:0]   req_weight_value;
   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   logic                        rsp_decision;
   logic signed [SUM_OUT_W-1:0] rsp_weighted_sum;
   logic                        rsp_mistake;
   logic                        csr_write_enable;
   logic signed [THRESH_W-1:0]  csr_write_data;

   perceptron_scoreboard board;
   int teacher[PIXELS];
   int burst_left = 0;
   int sent       = 0;
   int phases     = 0;
   int stall_mode = 0;
   int stall_left = 0;

   perceptron_classify_train_unit i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_opcode       (req_opcode),
      .req_pattern      (req_pattern),
      .req_target       (req_target),
      .req_weight_index (req_weight_index),
      .req_weight_value (req_weight_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_decision     (rsp_decision),
      .rsp_weighted_sum (rsp_weighted_sum),
      .rsp_mistake      (rsp_mistake),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   // clock
   always #5 clock = ~clock;

   // response stall, switching between free, light, heavy and periodic modes
   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_mode = $urandom_range(0, 3);
         stall_left = $urandom_range(20, 200);
      end
      stall_left--;
      case (stall_mode)
         0:       rsp_stall <= 1'b0;
         1:       rsp_stall <= ($urandom_range(0, 3) == 0);
         2:       rsp_stall <= ($urandom_range(0, 9) < 7);
         default: rsp_stall <= ((stall_left % 8) < 3);
      endcase
   end

   // sample both channels at the rising edge
   always @(posedge clock) begin
      if (reset === 1'b0) begin
         if (rsp_valid === 1'b1 && rsp_stall === 1'b0)
            board.check_response(rsp_decision, rsp_weighted_sum, rsp_mistake);
         if (req_valid === 1'b1 && req_stall === 1'b0)
            board.note_request(opcode_type'(req_opcode), req_pattern, req_target,
                               req_weight_index, req_weight_value);
      end
   end

   // sender bursts: idle for a random gap when a burst runs out
   task automatic pace();
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         case ($urandom_range(0, 5))
            0, 1:    gap = 0;
            5:       gap = $urandom_range(12, 30);
            default: gap = $urandom_range(1, 5);
         endcase
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
   endtask

   // drive one transaction and hold it until accepted
   task automatic send(opcode_type op, logic [PATTERN_W-1:0] pattern, logic target,
                       logic [INDEX_W-1:0] index, logic signed [VALUE_W-1:0] value);
      pace();
      req_valid        <= 1'b1;
      req_opcode       <= op;
      req_pattern      <= pattern;
      req_target       <= target;
      req_weight_index <= index;
      req_weight_value <= value;
      do @(posedge clock); while (req_stall !== 1'b0);
      @(negedge clock);
      sent++;
   endtask

   // hold off until every predicted response has come back
   task automatic drain();
      req_valid <= 1'b0;
      while (board.pending() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic set_threshold(int value);
      drain();
      csr_write_enable <= 1'b1;
      csr_write_data   <= THRESH_W'(value);
      @(negedge clock);
      csr_write_enable <= 1'b0;
      board.threshold = value;
      phases++;
   endtask

   // load every weight with one value
   task automatic fill(int value);
      for (int i = 0; i < PIXELS; i++)
         send(OP_WRITE, PATTERN_W'($urandom()), 1'($urandom()), INDEX_W'(i), VALUE_W'(value));
   endtask

   function automatic logic [PATTERN_W-1:0] random_pattern();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return ALL_PIXELS;
         2:       return PATTERN_W'(1) << $urandom_range(0, PIXELS - 1);
         3:       return ~(PATTERN_W'(1) << $urandom_range(0, PIXELS - 1));
         default: return PATTERN_W'($urandom());
      endcase
   endfunction

   // full weights against a threshold at either extreme, saturation both ways
   task automatic extreme_sequence(int value);
      logic [PATTERN_W-1:0] one_hot;
      one_hot = PATTERN_W'(1) << $urandom_range(0, PIXELS - 1);
      fill(value);
      send(OP_CLASSIFY, ALL_PIXELS, 1'b0, '0, '0);
      send(OP_TRAIN, ALL_PIXELS, 1'b0, '0, '0);
      send(OP_TRAIN, ALL_PIXELS, 1'b1, '0, '0);
      send(OP_TRAIN, one_hot, 1'b1, '0, '0);
      send(OP_TRAIN, one_hot, 1'b0, '0, '0);
      send(OP_CLASSIFY, ALL_PIXELS, 1'b1, '0, '0);
   endtask

   // mostly training against a hidden labeling, with classifies, writes and clears mixed in
   task automatic random_item();
      logic [PATTERN_W-1:0]      pattern;
      logic                      target;
      logic [INDEX_W-1:0]        index;
      logic signed [VALUE_W-1:0] value;
      int pick;
      int score;
      pattern = random_pattern();
      target  = 1'($urandom());
      index   = ($urandom_range(0, 7) == 0) ? INDEX_W'($urandom_range(PIXELS, 31))
                                            : INDEX_W'($urandom_range(0, PIXELS - 1));
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5: value = VALUE_W'(int'($urandom_range(0, 100)) - 50);
         6, 7:             value = VALUE_W'($urandom());
         8:                value = VALUE_W'(W_MAX);
         default:          value = VALUE_W'(W_MIN);
      endcase
      pick = $urandom_range(0, 299);
      if (pick < 165) begin
         score = 0;
         foreach (teacher[i]) if (pattern[i]) score += teacher[i];
         send(OP_TRAIN, pattern, score >= 0, index, value);
      end else if (pick < 180) begin
         send(OP_TRAIN, pattern, target, index, value);
      end else if (pick < 245) begin
         send(OP_CLASSIFY, pattern, target, index, value);
      end else if (pick < 292) begin
         send(OP_WRITE, pattern, target, index, value);
      end else if (pick < 294) begin
         fill($urandom_range(0, 1) ? W_MAX : W_MIN);
      end else begin
         send(OP_CLEAR, pattern, target, index, value);
      end
   endtask

   // main sequence
   initial begin
      int thresholds[N_PHASES];
      board            = new();
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_opcode       = OP_CLASSIFY;
      req_pattern      = '0;
      req_target       = 1'b0;
      req_weight_index = '0;
      req_weight_value = '0;
      csr_write_enable = 1'b0;
      csr_write_data   = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed part at the reset threshold of zero
      send(OP_CLASSIFY, '0, 1'b1, '0, '0);
      send(OP_CLASSIFY, ALL_PIXELS, 1'b0, 5'd31, -16'sd1);
      send(OP_TRAIN, ALL_PIXELS, 1'b0, '0, '0);
      send(OP_TRAIN, ALL_PIXELS, 1'b1, '0, '0);
      send(OP_TRAIN, ALL_PIXELS, 1'b1, '0, '0);
      send(OP_WRITE, ALL_PIXELS, 1'b1, 5'd0, VALUE_W'(W_MAX));
      send(OP_WRITE, '0, 1'b0, 5'd24, VALUE_W'(W_MIN));
      // writes above the last weight are dropped
      send(OP_WRITE, '0, 1'b0, 5'd25, 16'sh1234);
      send(OP_WRITE, '0, 1'b0, 5'd31, -16'sd1);
      send(OP_CLASSIFY, PATTERN_W'(1), 1'b0, '0, '0);
      send(OP_CLASSIFY, PATTERN_W'(1) << 24, 1'b0, '0, '0);
      // false negative pushes the top weight into saturation
      send(OP_TRAIN, (PATTERN_W'(1) << 24) | PATTERN_W'(1), 1'b1, '0, '0);
      send(OP_CLASSIFY, ALL_PIXELS, 1'b1, '0, '0);
      send(OP_WRITE, '0, 1'b0, 5'd1, VALUE_W'(W_MIN));
      send(OP_WRITE, '0, 1'b0, 5'd24, '0);
      send(OP_WRITE, '0, 1'b0, 5'd3, 16'sd1);
      // false positive pushes a weight at the minimum into saturation
      send(OP_TRAIN, PATTERN_W'(5'b01011), 1'b0, '0, '0);
      send(OP_CLASSIFY, PATTERN_W'(5'b01011), 1'b1, '0, '0);
      send(OP_CLEAR, ALL_PIXELS, 1'b1, 5'd7, 16'sd100);
      send(OP_CLASSIFY, ALL_PIXELS, 1'b1, 5'd12, -16'sd100);
      send(OP_WRITE, '0, 1'b1, 5'd24, 16'sh5555);
      send(OP_WRITE, '0, 1'b0, 5'd12, -16'sh5556);
      send(OP_TRAIN, ALL_PIXELS, 1'b0, '0, '0);

      // random phases, each at its own threshold
      thresholds[0] = T_MAX;
      thresholds[1] = T_MIN;
      thresholds[2] = 1;
      thresholds[3] = -1;
      thresholds[4] = int'($urandom_range(0, 200)) - 100;
      thresholds[5] = int'($urandom_range(0, T_MAX - T_MIN)) + T_MIN;
      thresholds[6] = int'($urandom_range(0, 4000)) - 2000;
      thresholds[7] = 0;
      for (int p = 0; p < N_PHASES; p++) begin
         set_threshold(thresholds[p]);
         foreach (teacher[i]) teacher[i] = int'($urandom_range(0, 16)) - 8;
         if (thresholds[p] == T_MAX) extreme_sequence(W_MAX);
         if (thresholds[p] == T_MIN) extreme_sequence(W_MIN);
         for (int k = 0; k < N_RANDOM / N_PHASES; k++) begin
            // pause mid-phase until the unit is empty
            if (k == N_RANDOM / (2 * N_PHASES)) drain();
            random_item();
         end
      end

      drain();
      repeat (6) @(negedge clock);
      $display("covered %0d transactions over %0d threshold settings, %0d training corrections",
               sent, phases, board.corrections);
      $display("weighted sums seen from %0d to %0d, %0d responses checked, %0d mismatches",
               board.sum_lo, board.sum_hi, board.checked, board.errors);
      if (board.errors == 0 && board.pending() == 0) begin
         $display("perceptron_classify_train_unit regression: pass");
      end else begin
         $display("perceptron_classify_train_unit regression: fail");
      end
      $finish;
   end

   // watchdog
   initial begin
      #10_000_000;
      $display("watchdog expired with %0d responses outstanding", board.pending());
      $display("perceptron_classify_train_unit regression: fail");
      $finish;
   end

endmodule
